>>> sv/assert_macros.svh
// Assertion macros for the RTL of the RASTA filter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> sv/rasta_pkg.sv
// Package with the types, constants and filter taps of the RASTA filter.
package rasta_pkg;

    localparam int MAX_COEFFS_DEF = 16;
    localparam int IDX_W          = 4;
    localparam int DATA_W         = 32;
    localparam int COEF_W         = 17;
    localparam int PROD_W         = DATA_W + COEF_W;
    localparam int ACC_W          = 50;
    localparam int FRAC_W         = 15;
    localparam int Q_W            = ACC_W - FRAC_W;
    localparam int STEP_W         = 3;
    localparam int TDATA_IN_W     = 40;
    localparam int TDATA_OUT_W    = 40;

    // Q15 taps: 0.2, 0.1 and 0.98.
    localparam logic signed [COEF_W-1:0] TAP_02 = 17'sd6554;
    localparam logic signed [COEF_W-1:0] TAP_01 = 17'sd3277;
    localparam logic signed [COEF_W-1:0] TAP_FB = 17'sd32113;

    localparam logic [ACC_W-1:0] ROUND_ADD = ACC_W'(16384);

    // Multiply steps, one product per step.
    localparam logic [STEP_W-1:0] STEP_X0   = 3'd0;
    localparam logic [STEP_W-1:0] STEP_X1   = 3'd1;
    localparam logic [STEP_W-1:0] STEP_X3   = 3'd2;
    localparam logic [STEP_W-1:0] STEP_X4   = 3'd3;
    localparam logic [STEP_W-1:0] STEP_Y1   = 3'd4;
    localparam logic [STEP_W-1:0] STEP_LAST = 3'd5;

    localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

    // History of one coefficient index: x1 is the newest past input.
    typedef struct packed {
        logic signed [DATA_W-1:0] y1;
        logic signed [DATA_W-1:0] x4;
        logic signed [DATA_W-1:0] x3;
        logic signed [DATA_W-1:0] x2;
        logic signed [DATA_W-1:0] x1;
    } t_entry;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_ABS,
        ST_ROUND,
        ST_WB
    } t_state;

endpackage

>>> sv/rasta_filter_cepstral.sv
// A filter transfer runs through the five products of the shared multiplier, the magnitude and
// rounding states and the history write-back before its result is registered on the output; no
// new transfer is taken until then. Clear transfers are taken whenever the FSM is idle.
// Reset (synchronous, active low) idles the FSM, empties the output register and marks all
// history entries invalid, so every history reads as zero until written again.
`include "assert_macros.svh"

module rasta_filter_cepstral #(
    parameter int MAX_COEFFS = rasta_pkg::MAX_COEFFS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Input stream.
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // Bits from low: coeff_index [3:0], sample_value [35:4], zero pad [39:36].
    input  logic [rasta_pkg::TDATA_IN_W-1:0]   i_s_tdata,
    // Bits from low: cmd [0].
    input  logic                               i_s_tuser,
    // Output stream.
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // Bits from low: filtered_value [31:0], out_index [35:32], zero pad [39:36].
    output logic [rasta_pkg::TDATA_OUT_W-1:0]  o_m_tdata
);

    // Address width of the history memory; a single entry still needs one bit.
    localparam int AW = (MAX_COEFFS > 1) ? $clog2(MAX_COEFFS) : 1;

    // ------------------------------------------------------------------
    // Input decode. The cmd bit in tuser selects clearing over filtering.
    // A filter transfer with an index at or above MAX_COEFFS is dropped without any effect.
    // ------------------------------------------------------------------
    logic [rasta_pkg::IDX_W-1:0]         w_in_idx;
    logic signed [rasta_pkg::DATA_W-1:0] w_in_x;
    logic [7:0]                          w_in_idx_ext;
    logic [AW-1:0]                       w_in_addr;
    logic                                w_in_range;
    logic                                w_s_xfer;
    logic                                w_clear;
    logic                                w_start;

    assign w_in_idx     = i_s_tdata[rasta_pkg::IDX_W-1:0];
    assign w_in_x       = i_s_tdata[rasta_pkg::IDX_W +: rasta_pkg::DATA_W];
    assign w_in_idx_ext = 8'(w_in_idx);
    assign w_in_addr    = w_in_idx_ext[AW-1:0];
    assign w_in_range   = int'(w_in_idx) < MAX_COEFFS;
    assign w_s_xfer     = i_s_tvalid && o_s_tready;
    assign w_clear      = w_s_xfer && i_s_tuser;
    assign w_start      = w_s_xfer && !i_s_tuser && w_in_range;

    // ------------------------------------------------------------------
    // Control state machine.
    // ------------------------------------------------------------------
    rasta_pkg::t_state r_state, n_state;
    logic [rasta_pkg::STEP_W-1:0] r_step, n_step;
    logic w_out_free;
    logic w_commit;

    assign w_out_free = !o_m_tvalid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rasta_pkg::ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        o_s_tready = 1'b0;
        w_commit   = 1'b0;
        case (r_state)
            rasta_pkg::ST_IDLE: begin
                o_s_tready = 1'b1;
                n_step     = '0;
                if (w_start) begin
                    n_state = rasta_pkg::ST_MAC;
                end
            end
            rasta_pkg::ST_MAC: begin
                n_step = r_step + 3'd1;
                if (r_step == rasta_pkg::STEP_LAST) begin
                    n_state = rasta_pkg::ST_ABS;
                end
            end
            rasta_pkg::ST_ABS: begin
                n_state = rasta_pkg::ST_ROUND;
            end
            rasta_pkg::ST_ROUND: begin
                n_state = rasta_pkg::ST_WB;
            end
            rasta_pkg::ST_WB: begin
                // Write back and hand the result over once the output register is free.
                if (w_out_free) begin
                    w_commit = 1'b1;
                    n_state  = rasta_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rasta_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // History memory: one entry per index holding the four past inputs and
    // the past output. The read is issued at the input transfer and its data
    // is registered; the write-back finishes before the next read, so the
    // same entry is never read and written in overlapping items. A valid bit
    // per entry stands for the all-zero reset and clear value.
    // ------------------------------------------------------------------
    rasta_pkg::t_entry r_mem [MAX_COEFFS];
    rasta_pkg::t_entry r_rd_data;
    logic              r_rd_valid;
    logic [MAX_COEFFS-1:0] r_valid;
    logic [AW-1:0]     r_addr;
    logic [rasta_pkg::IDX_W-1:0] r_idx;
    logic signed [rasta_pkg::DATA_W-1:0] r_x;
    rasta_pkg::t_entry w_hist;
    rasta_pkg::t_entry w_wr_data;
    logic signed [rasta_pkg::DATA_W-1:0] w_y;

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_rd_data <= r_mem[w_in_addr];
            r_addr    <= w_in_addr;
            r_idx     <= w_in_idx;
            r_x       <= w_in_x;
        end
        if (w_commit) begin
            r_mem[r_addr] <= w_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (w_start) begin
                r_rd_valid <= r_valid[w_in_addr];
            end
            if (w_clear) begin
                r_valid <= '0;
            end else if (w_commit) begin
                r_valid[r_addr] <= 1'b1;
            end
        end
    end

    assign w_hist = r_rd_valid ? r_rd_data : '0;

    // ------------------------------------------------------------------
    // Shared multiplier: one product per step, registered, then summed.
    // ------------------------------------------------------------------
    logic signed [rasta_pkg::DATA_W-1:0] w_op;
    logic signed [rasta_pkg::COEF_W-1:0] w_coef;
    logic signed [rasta_pkg::PROD_W-1:0] r_prod;
    logic signed [rasta_pkg::ACC_W-1:0]  r_acc;

    always_comb begin
        case (r_step)
            rasta_pkg::STEP_X0: begin
                w_op   = r_x;
                w_coef = rasta_pkg::TAP_02;
            end
            rasta_pkg::STEP_X1: begin
                w_op   = w_hist.x1;
                w_coef = rasta_pkg::TAP_01;
            end
            rasta_pkg::STEP_X3: begin
                w_op   = w_hist.x3;
                w_coef = -rasta_pkg::TAP_01;
            end
            rasta_pkg::STEP_X4: begin
                w_op   = w_hist.x4;
                w_coef = -rasta_pkg::TAP_02;
            end
            rasta_pkg::STEP_Y1: begin
                w_op   = w_hist.y1;
                w_coef = rasta_pkg::TAP_FB;
            end
            default: begin
                w_op   = '0;
                w_coef = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == rasta_pkg::ST_MAC) begin
            r_prod <= rasta_pkg::PROD_W'(w_op) * rasta_pkg::PROD_W'(w_coef);
            if (r_step == rasta_pkg::STEP_X1) begin
                r_acc <= rasta_pkg::ACC_W'(r_prod);
            end else if (r_step != rasta_pkg::STEP_X0) begin
                r_acc <= r_acc + rasta_pkg::ACC_W'(r_prod);
            end
        end
    end

    // ------------------------------------------------------------------
    // Rounding half away from zero: take the magnitude, add one half of the
    // Q15 step and drop the fraction; then restore the sign and saturate.
    // ------------------------------------------------------------------
    logic                          r_neg;
    logic [rasta_pkg::ACC_W-1:0]   r_mag;
    logic [rasta_pkg::Q_W-1:0]     r_q;
    logic [rasta_pkg::ACC_W-1:0]   w_rsum;

    assign w_rsum = r_mag + rasta_pkg::ROUND_ADD;

    always_ff @(posedge i_clk) begin
        if (r_state == rasta_pkg::ST_ABS) begin
            r_neg <= r_acc[rasta_pkg::ACC_W-1];
            r_mag <= r_acc[rasta_pkg::ACC_W-1] ? unsigned'(-r_acc) : unsigned'(r_acc);
        end
        if (r_state == rasta_pkg::ST_ROUND) begin
            r_q <= w_rsum[rasta_pkg::ACC_W-1:rasta_pkg::FRAC_W];
        end
    end

    // Any magnitude of 2^31 or more clips; for negative sums 2^31 itself is the minimum.
    always_comb begin
        if (r_q[rasta_pkg::Q_W-1:rasta_pkg::DATA_W-1] != '0) begin
            w_y = r_neg ? rasta_pkg::SAT_MIN : rasta_pkg::SAT_MAX;
        end else if (r_neg) begin
            w_y = -signed'(r_q[rasta_pkg::DATA_W-1:0]);
        end else begin
            w_y = signed'(r_q[rasta_pkg::DATA_W-1:0]);
        end
    end

    // Shift the input history by one and store the new output as feedback.
    always_comb begin
        w_wr_data.x1 = r_x;
        w_wr_data.x2 = w_hist.x1;
        w_wr_data.x3 = w_hist.x2;
        w_wr_data.x4 = w_hist.x3;
        w_wr_data.y1 = w_y;
    end

    // ------------------------------------------------------------------
    // Output register. It holds a finished result while the downstream side
    // stalls, and the input side stays open for new transfers meanwhile.
    // ------------------------------------------------------------------
    logic                                 r_out_valid;
    logic signed [rasta_pkg::DATA_W-1:0]  r_out_y;
    logic [rasta_pkg::IDX_W-1:0]          r_out_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_commit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_out_y   <= w_y;
            r_out_idx <= r_idx;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {
        {(rasta_pkg::TDATA_OUT_W - rasta_pkg::DATA_W - rasta_pkg::IDX_W){1'b0}},
        r_out_idx, r_out_y
    };

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `ASSERT_NEXT(a_clear_empties, w_clear, r_valid == '0, "clear left a valid history entry")
    `ASSERT_SAME(a_commit_in_wb, w_commit,
        r_state == rasta_pkg::ST_WB && w_out_free,
        "write-back outside its state or into a busy output")
    `ASSERT_SAME(a_rise_after_wb, $rose(o_m_tvalid),
        $past(r_state) == rasta_pkg::ST_WB,
        "result appeared without a write-back")
    `ASSERT_ALWAYS(a_step_range,
        r_state != rasta_pkg::ST_MAC || r_step <= rasta_pkg::STEP_LAST,
        "multiply step ran past the last tap")

endmodule
